// ----- rtl/rdf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdf_pkg
// Shared types, constants and the digit-to-ASCII mapping for the radix
// digit formatter.
// ----------------------------------------------------------------------------
package rdf_pkg;

	localparam int VALUE_BITS_DEF = 31;
	localparam int RADIX_W        = 6;
	localparam int CHAR_W         = 7;

	localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
	localparam logic [RADIX_W-1:0] DEC_BASE  = 6'd10;
	localparam logic [CHAR_W-1:0]  ASCII_ZERO = 7'h30;
	localparam logic [CHAR_W-1:0]  ASCII_A    = 7'h41;
	localparam logic [CHAR_W-1:0]  ERR_CHAR   = 7'h00;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_RD,
		S_OUT
	} rdf_state_t;

	// status from the shared divider back to the sequencer
	typedef struct packed {
		logic               done;
		logic [RADIX_W-1:0] rem;
	} div_res_t;

	function automatic logic [CHAR_W-1:0] ascii_of(input logic [RADIX_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < DEC_BASE) begin
			c = ASCII_ZERO + CHAR_W'(d);
		end else begin
			c = ASCII_A + CHAR_W'(d - DEC_BASE);
		end
		return c;
	endfunction

endpackage

// ----- rtl/radix_digit_formatter.sv -----
`timescale 1ns / 1ps
// A bad radix gives its single result in the cycle after the request.
// Otherwise each digit comes from the bit-serial divider, then each digit
// plays out through the store read and then the output register.
// One request at a time; busy stays high until the last digit is registered.
// Reset (async, active low) returns to idle and drops the result strobe.
// ----------------------------------------------------------------------------
// radix_digit_formatter
// Converts an unsigned integer to ASCII digits in radix 2..36, most
// significant digit first, using one shared serial divider and a digit store.
// ----------------------------------------------------------------------------
module radix_digit_formatter #(
	parameter int VALUE_BITS = rdf_pkg::VALUE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [VALUE_BITS-1:0]       value,
	input  logic [rdf_pkg::RADIX_W-1:0] radix,
	output logic                        valid,
	output logic [rdf_pkg::CHAR_W-1:0]  digit_char,
	output logic                        last_digit,
	output logic                        bad_radix
);
	import rdf_pkg::*;

	localparam int IDX_W = $clog2(VALUE_BITS);
	localparam int CNT_W = $clog2(VALUE_BITS + 1);

	rdf_state_t state_q, state_d;

	logic [CNT_W-1:0]    count_q, count_d;
	logic [IDX_W-1:0]    rptr_q, rptr_d;
	logic                valid_q, valid_d;
	logic [CHAR_W-1:0]   char_q, char_d;
	logic                last_q, last_d;
	logic                bad_q, bad_d;

	logic                  accept;
	logic                  radix_ok;
	logic                  div_go;
	logic [VALUE_BITS-1:0] div_dividend;
	logic [RADIX_W-1:0]    div_divisor;
	logic [VALUE_BITS-1:0] div_quot;
	div_res_t              div_res;
	logic                  wr_en;
	logic                  rd_en;
	logic [RADIX_W-1:0]    rd_data;
	logic [CNT_W-1:0]      cnt_inc;
	logic [RADIX_W-1:0]    radix_q;

	assign busy     = (state_q != S_IDLE);
	assign accept   = start && !busy;
	assign radix_ok = radix inside {[RADIX_MIN:RADIX_MAX]};
	assign cnt_inc  = count_q + 1'b1;

	// first division takes the request value, later ones the running quotient
	assign div_dividend = (state_q == S_IDLE) ? value : div_quot;
	assign div_divisor  = (state_q == S_IDLE) ? radix : radix_q;

	rdf_divider #(
		.VALUE_BITS(VALUE_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quot),
		.res      (div_res)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			radix_q <= radix;
		end
	end

	rdf_digit_store #(
		.VALUE_BITS(VALUE_BITS)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[IDX_W-1:0]),
		.wr_data (div_res.rem),
		.rd_en   (rd_en),
		.rd_addr (rptr_q),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			rptr_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			rptr_q  <= rptr_d;
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		char_q <= char_d;
		last_q <= last_d;
		bad_q  <= bad_d;
	end

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		rptr_d  = rptr_q;
		valid_d = 1'b0;
		char_d  = char_q;
		last_d  = last_q;
		bad_d   = bad_q;
		div_go  = 1'b0;
		wr_en   = 1'b0;
		rd_en   = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (radix_ok) begin
						// divider latches radix directly; radix_q not yet loaded
						div_go  = 1'b1;
						count_d = '0;
						state_d = S_DIV;
					end else begin
						valid_d = 1'b1;
						char_d  = ERR_CHAR;
						last_d  = 1'b1;
						bad_d   = 1'b1;
					end
				end
			end
			S_DIV: begin
				if (div_res.done) begin
					wr_en   = 1'b1;
					count_d = cnt_inc;
					if (div_quot == '0 || cnt_inc == CNT_W'(VALUE_BITS)) begin
						rptr_d  = IDX_W'(count_q);
						state_d = S_RD;
					end else begin
						div_go = 1'b1;
					end
				end
			end
			S_RD: begin
				rd_en   = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				valid_d = 1'b1;
				char_d  = ascii_of(rd_data);
				last_d  = (rptr_q == '0);
				bad_d   = 1'b0;
				if (rptr_q == '0) begin
					state_d = S_IDLE;
				end else begin
					rptr_d  = rptr_q - 1'b1;
					state_d = S_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign valid      = valid_q;
	assign digit_char = char_q;
	assign last_digit = last_q;
	assign bad_radix  = bad_q;

	a_bad_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && bad_radix |-> last_digit)
		else $error("bad radix result without last flag");

	a_more_digits_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !last_digit |-> busy)
		else $error("non-final digit while sequencer idle");

	a_bad_radix_reply: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !radix_ok |=> valid && bad_radix && !busy)
		else $error("bad radix request not answered next cycle");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(VALUE_BITS))
		else $error("digit count beyond store depth");

endmodule

// ----- rtl/rdf_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdf_divider
// Bit-serial restoring divider: one quotient bit per cycle, remainder below
// the 6-bit divisor.
// ----------------------------------------------------------------------------
module rdf_divider #(
	parameter int VALUE_BITS = rdf_pkg::VALUE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        go,
	input  logic [VALUE_BITS-1:0]       dividend,
	input  logic [rdf_pkg::RADIX_W-1:0] divisor,
	output logic [VALUE_BITS-1:0]       quotient,
	output rdf_pkg::div_res_t           res
);
	import rdf_pkg::*;

	localparam int IDX_W = $clog2(VALUE_BITS);

	logic [VALUE_BITS-1:0] dvd_q;
	logic [RADIX_W-1:0]    dvs_q;
	logic [RADIX_W-1:0]    rem_q;
	logic [IDX_W-1:0]      step_q;
	logic                  run_q;
	logic                  done_q;

	logic [RADIX_W:0]   rem_shift;
	logic               ge;
	logic [RADIX_W-1:0] rem_next;

	always_comb begin
		rem_shift = {rem_q, dvd_q[VALUE_BITS-1]};
		ge        = rem_shift >= {1'b0, dvs_q};
		rem_next  = ge ? RADIX_W'(rem_shift - {1'b0, dvs_q}) : RADIX_W'(rem_shift);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q  <= 1'b1;
				step_q <= IDX_W'(VALUE_BITS - 1);
			end else if (run_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[VALUE_BITS-2:0], ge};
			rem_q <= rem_next;
		end
	end

	assign quotient = dvd_q;
	assign res.done = done_q;
	assign res.rem  = rem_q;

endmodule

// ----- rtl/rdf_digit_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdf_digit_store
// Digit memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rdf_digit_store #(
	parameter int VALUE_BITS = rdf_pkg::VALUE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              wr_en,
	input  logic [$clog2(VALUE_BITS)-1:0]     wr_addr,
	input  logic [rdf_pkg::RADIX_W-1:0]       wr_data,
	input  logic                              rd_en,
	input  logic [$clog2(VALUE_BITS)-1:0]     rd_addr,
	output logic [rdf_pkg::RADIX_W-1:0]       rd_data
);
	import rdf_pkg::*;

	logic [RADIX_W-1:0] mem [VALUE_BITS];
	logic [RADIX_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
